FILE: src/pbwa_pkg.sv
// Shared types, codes and constants for the PCI BAR window allocator.
`default_nettype none

package pbwa_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int IDE_ID_WIDTH = 25;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IO_ALLOC_START = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEM_ALLOC_START = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDE_FUNCTION_ID = 2'd2;

   localparam logic [31:0] IO_ALLOC_START_RESET = 32'h0000_1000;
   localparam logic [31:0] MEM_ALLOC_START_RESET = 32'h0000_0000;
   localparam logic [IDE_ID_WIDTH-1:0] IDE_FUNCTION_ID_RESET = 25'h1ff_ffff;

   localparam logic [31:0] IO_UPPER_FILL = 32'hffff_0000;
   localparam logic [31:0] IO_FLAG_MASK = ~32'd3;
   localparam logic [31:0] MEM_FLAG_MASK = ~32'd15;
   localparam logic [2:0] MEM_TYPE_64BIT = 3'b100;

   localparam logic [31:0] IDE_ADDR_BAR0 = 32'h0000_01f0;
   localparam logic [31:0] IDE_ADDR_BAR1 = 32'h0000_03f4;
   localparam logic [31:0] IDE_ADDR_BAR2 = 32'h0000_0170;
   localparam logic [31:0] IDE_ADDR_BAR3 = 32'h0000_0374;
   localparam logic [31:0] IDE_ADDR_BAR4 = 32'h0000_0cc0;

   typedef enum logic [2:0] {
      STATUS_ASSIGNED = 3'd0,
      STATUS_UNIMPLEMENTED = 3'd1,
      STATUS_NOT_POW2 = 3'd2,
      STATUS_IDE_FIXED = 3'd3,
      STATUS_IDE_NO_BAR = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] bus_number;
      logic [4:0] slot_number;
      logic [2:0] function_number;
      logic [2:0] bar_index;
      logic [31:0] size_readback;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [31:0] bar_value;
      logic [1:0] bar_step;
      logic clear_upper;
   } rsp_type;

   typedef struct packed {
      logic [31:0] io_next;
      logic [31:0] mem_next;
      logic [IDE_ID_WIDTH-1:0] ide_function_id;
   } state_type;

   typedef struct packed {
      logic io_update;
      logic mem_update;
      logic [31:0] next_value;
   } update_type;

endpackage

`default_nettype wire

FILE: src/pbwa_calc.sv
// Combinational BAR sizing, alignment and pointer bump for one transaction.
`default_nettype none

module pbwa_calc (
   input  pbwa_pkg::req_type    req_data,
   input  pbwa_pkg::state_type  state,
   output pbwa_pkg::rsp_type    rsp_data,
   output pbwa_pkg::update_type update
);
   import pbwa_pkg::*;

   logic [23:0] dev_id;
   logic        ide_hit;
   logic        is_io;
   logic        is_64bit;
   logic [31:0] io_size;
   logic [31:0] size_bits;
   logic [31:0] mask;
   logic [31:0] window;
   logic        pow2;
   logic [31:0] base_ptr;
   logic [31:0] addr;
   logic [31:0] ide_addr;
   logic [1:0]  step;

   assign dev_id = {req_data.bus_number, 3'b000, req_data.slot_number, 5'b00000,
                    req_data.function_number};
   assign ide_hit = !state.ide_function_id[IDE_ID_WIDTH-1]
                    && (dev_id == state.ide_function_id[23:0]);

   assign is_io = req_data.size_readback[0];
   assign is_64bit = (req_data.size_readback[2:0] == MEM_TYPE_64BIT);
   assign step = is_64bit ? 2'd2 : 2'd1;

   always_comb begin
      io_size = req_data.size_readback & IO_FLAG_MASK;
      if ((io_size & IO_UPPER_FILL) == 32'd0) begin
         io_size = io_size | IO_UPPER_FILL;
      end
   end

   assign size_bits = is_io ? io_size : (req_data.size_readback & MEM_FLAG_MASK);
   assign mask = ~size_bits;
   assign window = mask + 32'd1;
   assign pow2 = ((window & mask) == 32'd0);
   assign base_ptr = is_io ? state.io_next : state.mem_next;
   assign addr = (base_ptr + mask) & ~mask;

   always_comb begin
      unique case (req_data.bar_index)
         3'd0: ide_addr = IDE_ADDR_BAR0;
         3'd1: ide_addr = IDE_ADDR_BAR1;
         3'd2: ide_addr = IDE_ADDR_BAR2;
         3'd3: ide_addr = IDE_ADDR_BAR3;
         3'd4: ide_addr = IDE_ADDR_BAR4;
         default: ide_addr = 32'd0;
      endcase
   end

   always_comb begin
      rsp_data.status = STATUS_ASSIGNED;
      rsp_data.bar_value = 32'd0;
      rsp_data.bar_step = 2'd1;
      rsp_data.clear_upper = 1'b0;
      update.io_update = 1'b0;
      update.mem_update = 1'b0;
      update.next_value = addr + window;
      priority if (ide_hit) begin
         if (req_data.bar_index < 3'd5) begin
            rsp_data.status = STATUS_IDE_FIXED;
            rsp_data.bar_value = ide_addr;
         end else begin
            rsp_data.status = STATUS_IDE_NO_BAR;
         end
      end else if (req_data.size_readback == 32'd0) begin
         rsp_data.status = STATUS_UNIMPLEMENTED;
      end else if (!pow2) begin
         rsp_data.status = STATUS_NOT_POW2;
         rsp_data.bar_step = step;
      end else begin
         rsp_data.bar_value = addr;
         rsp_data.bar_step = step;
         rsp_data.clear_upper = is_64bit;
         update.io_update = is_io;
         update.mem_update = !is_io;
      end
   end

endmodule

`default_nettype wire

FILE: src/pbwa_ptrs.sv
// Configuration registers and the I/O and memory allocation pointers.
`default_nettype none

module pbwa_ptrs (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_write_enable,
   input  wire [pbwa_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire [pbwa_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   input  wire                                    commit,
   input  pbwa_pkg::update_type                   update,
   output pbwa_pkg::state_type                    state
);
   import pbwa_pkg::*;

   logic [31:0]             io_next_ff, io_next_in;
   logic [31:0]             mem_next_ff, mem_next_in;
   logic [IDE_ID_WIDTH-1:0] ide_id_ff, ide_id_in;

   always_comb begin
      io_next_in = io_next_ff;
      mem_next_in = mem_next_ff;
      ide_id_in = ide_id_ff;
      if (commit && update.io_update) begin
         io_next_in = update.next_value;
      end
      if (commit && update.mem_update) begin
         mem_next_in = update.next_value;
      end
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IO_ALLOC_START: io_next_in = csr_write_data;
            CSR_MEM_ALLOC_START: mem_next_in = csr_write_data;
            CSR_IDE_FUNCTION_ID: ide_id_in = csr_write_data[IDE_ID_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         io_next_ff <= IO_ALLOC_START_RESET;
         mem_next_ff <= MEM_ALLOC_START_RESET;
         ide_id_ff <= IDE_FUNCTION_ID_RESET;
      end else begin
         io_next_ff <= io_next_in;
         mem_next_ff <= mem_next_in;
         ide_id_ff <= ide_id_in;
      end
   end

   assign state.io_next = io_next_ff;
   assign state.mem_next = mem_next_ff;
   assign state.ide_function_id = ide_id_ff;

endmodule

`default_nettype wire

FILE: src/pci_bar_window_allocator.sv
// Top level of the PCI BAR window allocator: input register, compute, result register.
// A request waits in the input register, its result in the result register on rsp.
// Throughput: one transaction per cycle, as long as rsp_ready does not stall the result.
// The input and result registers let a new transaction in while a result waits.
// Reset is synchronous and active high; it empties both stages and restores
// the start addresses, the pointers and the IDE function id to their defaults.
`default_nettype none

module pci_bar_window_allocator (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  pbwa_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output pbwa_pkg::rsp_type                      rsp_data,
   input  wire                                    csr_write_enable,
   input  wire [pbwa_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire [pbwa_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);
   import pbwa_pkg::*;

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff, in_data_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;
   logic       advance;
   logic       accept;
   logic       commit;
   rsp_type    calc_rsp;
   update_type calc_update;
   state_type  state;

   assign advance = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign accept = req_valid && req_ready;
   assign commit = in_valid_ff && advance;

   pbwa_calc u_calc (
      .req_data (in_data_ff),
      .state    (state),
      .rsp_data (calc_rsp),
      .update   (calc_update)
   );

   pbwa_ptrs u_ptrs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .commit           (commit),
      .update           (calc_update),
      .state            (state)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         out_valid_in = in_valid_ff;
      end
      if (commit) begin
         out_data_in = calc_rsp;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_data_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

endmodule

`default_nettype wire

FILE: src/pbwa_checker.sv
// Port-level assertions for the PCI BAR window allocator and their bind.
`default_nettype none

module pbwa_checker (
   input wire                clock,
   input wire                reset,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input pbwa_pkg::rsp_type  rsp_data
);
   import pbwa_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result offered right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result changed or dropped.");

   a_clear_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clear_upper |->
         rsp_data.status == STATUS_ASSIGNED && rsp_data.bar_step == 2'd2)
      else $error("Upper word cleared for a BAR that is not an assigned 64-bit one.");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_UNIMPLEMENTED
                    || rsp_data.status == STATUS_NOT_POW2
                    || rsp_data.status == STATUS_IDE_NO_BAR)
      |-> rsp_data.bar_value == 32'd0 && !rsp_data.clear_upper)
      else $error("Address given for a BAR that was not assigned.");

   a_ide_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_IDE_FIXED
                    || rsp_data.status == STATUS_IDE_NO_BAR
                    || rsp_data.status == STATUS_UNIMPLEMENTED)
      |-> rsp_data.bar_step == 2'd1)
      else $error("Fixed or unimplemented BAR reported a double step.");

endmodule

bind pci_bar_window_allocator pbwa_checker u_pbwa_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
